FILE: design/owik_pkg.sv
// Package for the omni wheel inverse kinematics block.
// Holds field widths, register indexes, CORDIC constants and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package owik_pkg;
  localparam int AngleBits = 16;
  localparam int CordicSteps = 16;
  localparam int CordicW = 33;
  localparam logic signed [CordicW-1:0] CordicX0 = 33'sd652032874;
  localparam logic [23:0] EighthUnits = 24'd2097152;

  localparam logic [1:0] RegDiagGain = 2'd0;
  localparam logic [1:0] RegYawGain = 2'd1;
  localparam logic [1:0] RegWheelLimit = 2'd2;

  localparam logic [15:0] DiagGainRst = 16'd9051;
  localparam logic [15:0] YawGainRst = 16'd12800;
  localparam logic [15:0] WheelLimitRst = 16'd51200;

  typedef struct packed {
    logic [15:0] diag_gain;
    logic [15:0] yaw_gain;
    logic [15:0] wheel_limit;
  } cfg_t;

  function automatic logic signed [23:0] atan_units(input int idx);
    logic signed [23:0] r;
    case (idx)
      0: r = 24'sd2097152;
      1: r = 24'sd1238021;
      2: r = 24'sd654136;
      3: r = 24'sd332050;
      4: r = 24'sd166669;
      5: r = 24'sd83416;
      6: r = 24'sd41718;
      7: r = 24'sd20860;
      8: r = 24'sd10430;
      9: r = 24'sd5215;
      10: r = 24'sd2608;
      11: r = 24'sd1304;
      12: r = 24'sd652;
      13: r = 24'sd326;
      14: r = 24'sd163;
      15: r = 24'sd81;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction
endpackage

FILE: design/owik_cordic.sv
// Pipelined CORDIC giving cosine and sine of a binary angle in Q1.30.
// One rotation step per register stage, with an enable for stalls. Uses owik_pkg.
`timescale 1ns / 1ps
module owik_cordic import owik_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [15:0]                angle_i,
  output logic signed [CordicW-1:0]  cos_o,
  output logic signed [CordicW-1:0]  sin_o
);
  logic signed [CordicW-1:0] x_q [CordicSteps+1];
  logic signed [CordicW-1:0] y_q [CordicSteps+1];
  logic signed [23:0]        z_q [CordicSteps+1];
  logic [1:0]                quad_q [CordicSteps+1];
  logic [23:0]               a_d;
  logic [23:0]               t_d;

  always_comb begin
    a_d = {angle_i, 8'd0};
    a_d[23-AngleBits:0] = '0;
    t_d = a_d + EighthUnits;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicX0;
      y_q[0] <= '0;
      z_q[0] <= $signed({2'b00, t_d[21:0]}) - $signed(EighthUnits);
      quad_q[0] <= t_d[23:22];
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][23]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_units(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_units(i);
        end
      end
    end
  end

  always_comb begin
    case (quad_q[CordicSteps])
      2'd0: begin cos_o = x_q[CordicSteps];  sin_o = y_q[CordicSteps];  end
      2'd1: begin cos_o = -y_q[CordicSteps]; sin_o = x_q[CordicSteps];  end
      2'd2: begin cos_o = -x_q[CordicSteps]; sin_o = -y_q[CordicSteps]; end
      default: begin cos_o = y_q[CordicSteps]; sin_o = -x_q[CordicSteps]; end
    endcase
  end
endmodule

FILE: design/owik_wheel.sv
// Wheel speed path: gain products, sign mixing, rounding and clamp.
// Three register stages, advancing on the shared enable. Uses owik_pkg.
`timescale 1ns / 1ps
module owik_wheel import owik_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  cfg_t                cfg_i,
  input  logic signed [15:0]  vx_i,
  input  logic signed [15:0]  vy_i,
  input  logic signed [15:0]  yaw_i,
  output logic signed [16:0]  speed_o [4]
);
  logic signed [32:0] px_q, py_q, pw_q;
  logic signed [35:0] sum_q [4];
  logic signed [16:0] spd_q [4];
  logic signed [35:0] px_e, py_e, pw_e;
  logic signed [35:0] s_d [4];
  logic signed [27:0] r_d [4];
  logic signed [27:0] lim_d;

  assign px_e = 36'(px_q);
  assign py_e = 36'(py_q);
  assign pw_e = 36'(pw_q);
  assign lim_d = $signed({12'd0, cfg_i.wheel_limit});

  always_comb begin
    s_d[0] = -px_e + py_e + pw_e;
    s_d[1] = -px_e - py_e + pw_e;
    s_d[2] = px_e - py_e + pw_e;
    s_d[3] = px_e + py_e + pw_e;
    for (int k = 0; k < 4; k++) begin
      r_d[k] = 28'((sum_q[k] + 36'sd128) >>> 8);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= $signed({1'b0, cfg_i.diag_gain}) * vx_i;
      py_q <= $signed({1'b0, cfg_i.diag_gain}) * vy_i;
      pw_q <= $signed({1'b0, cfg_i.yaw_gain}) * yaw_i;
      for (int k = 0; k < 4; k++) begin
        sum_q[k] <= s_d[k];
        if (r_d[k] > lim_d) begin
          spd_q[k] <= 17'(lim_d);
        end else if (r_d[k] < -lim_d) begin
          spd_q[k] <= 17'(-lim_d);
        end else begin
          spd_q[k] <= 17'(r_d[k]);
        end
      end
    end
  end

  assign speed_o = spd_q;
endmodule

FILE: design/owik_rotate.sv
// Rotation of the body velocity into the world frame with rounding and saturation.
// Products, sum and saturate stages on the shared enable. Uses owik_pkg.
`timescale 1ns / 1ps
module owik_rotate import owik_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [CordicW-1:0]  cos_i,
  input  logic signed [CordicW-1:0]  sin_i,
  input  logic signed [15:0]         vx_i,
  input  logic signed [15:0]         vy_i,
  output logic signed [16:0]         wx_o,
  output logic signed [16:0]         wy_o
);
  logic signed [48:0] cx_q, sy_q, sx_q, cy_q;
  logic signed [50:0] wx_q, wy_q;
  logic signed [16:0] ox_q, oy_q;
  logic signed [20:0] rx_d, ry_d;

  assign rx_d = 21'((wx_q + (51'sd1 <<< 29)) >>> 30);
  assign ry_d = 21'((wy_q + (51'sd1 <<< 29)) >>> 30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= cos_i * vx_i;
      sy_q <= sin_i * vy_i;
      sx_q <= sin_i * vx_i;
      cy_q <= cos_i * vy_i;
      wx_q <= 51'(cx_q) - 51'(sy_q);
      wy_q <= 51'(sx_q) + 51'(cy_q);
      ox_q <= (rx_d > 21'sd65535) ? 17'sd65535 :
              (rx_d < -21'sd65536) ? -17'sd65536 : 17'(rx_d);
      oy_q <= (ry_d > 21'sd65535) ? 17'sd65535 :
              (ry_d < -21'sd65536) ? -17'sd65536 : 17'(ry_d);
    end
  end

  assign wx_o = ox_q;
  assign wy_o = oy_q;
endmodule

FILE: design/omni_wheel_inverse_kinematics.sv
// Top level of the omni wheel inverse kinematics block.
// Uses owik_pkg, owik_cordic, owik_wheel and owik_rotate.
`timescale 1ns / 1ps
// The block accepts one transaction per cycle while the output is not stalled,
// and returns one result per transaction, in order, through the angle reduction
// stage, the 16-step CORDIC and a 3-stage rotate path. The whole
// pipeline holds while the output is stalled. Write configuration only when
// the block is empty.
module omni_wheel_inverse_kinematics import owik_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // body_vx, body_vy, body_yaw_rate, heading
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // wheel_speed_a, _b, _c, _d, world_vx, world_vy, world_yaw_rate, zero fill
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  localparam int Lat = CordicSteps + 4;

  cfg_t cfg_q;
  logic [Lat-1:0] vld_q;
  logic en;
  logic signed [15:0] vx, vy, yaw;
  logic signed [15:0] yaw_q [Lat];
  logic signed [15:0] vxd_q [CordicSteps+1];
  logic signed [15:0] vyd_q [CordicSteps+1];
  logic signed [CordicW-1:0] cs, sn;
  logic signed [16:0] spd [4];
  logic signed [16:0] spd_q [4];
  logic signed [16:0] spd2_q [4];
  logic signed [16:0] wx, wy;

  assign vx = s_axis_tdata[15:0];
  assign vy = s_axis_tdata[31:16];
  assign yaw = s_axis_tdata[47:32];

  assign en = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cfg_q <= '{DiagGainRst, YawGainRst, WheelLimitRst};
    end else begin
      if (en) begin
        vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegDiagGain: cfg_q.diag_gain <= cfg_data_i;
          RegYawGain: cfg_q.yaw_gain <= cfg_data_i;
          RegWheelLimit: cfg_q.wheel_limit <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q[0] <= yaw;
      vxd_q[0] <= vx;
      vyd_q[0] <= vy;
      for (int i = 1; i < Lat; i++) yaw_q[i] <= yaw_q[i-1];
      for (int i = 1; i <= CordicSteps; i++) begin
        vxd_q[i] <= vxd_q[i-1];
        vyd_q[i] <= vyd_q[i-1];
      end
    end
  end

  // Wheel path finishes after 3 stages; pad it to the rotate latency.
  for (genvar k = 0; k < 4; k++) begin : g_pad
    logic signed [16:0] d_q [Lat-3];
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q[0] <= spd[k];
        for (int i = 1; i < Lat - 3; i++) d_q[i] <= d_q[i-1];
      end
    end
    assign spd_q[k] = d_q[Lat-4];
  end
  assign spd2_q = spd_q;

  owik_cordic u_cordic (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[63:48]), .cos_o(cs), .sin_o(sn)
  );

  owik_wheel u_wheel (
    .clk_i, .en_i(en), .cfg_i(cfg_q), .vx_i(vx), .vy_i(vy), .yaw_i(yaw),
    .speed_o(spd)
  );

  owik_rotate u_rotate (
    .clk_i, .en_i(en), .cos_i(cs), .sin_i(sn),
    .vx_i(vxd_q[CordicSteps]), .vy_i(vyd_q[CordicSteps]), .wx_o(wx), .wy_o(wy)
  );

  assign m_axis_tdata = {2'b00, yaw_q[Lat-1], wy, wx,
                         spd2_q[3], spd2_q[2], spd2_q[1], spd2_q[0]};
endmodule

FILE: design/owik_checker.sv
// Port-level checker for the omni wheel inverse kinematics block.
// Bound to the top level; no package needed.
`timescale 1ns / 1ps
module owik_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed.");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while output is empty.");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Input taken while output stalled.");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[119:118] == 2'b00)
    else $error("Fill bits not zero.");
endmodule

bind omni_wheel_inverse_kinematics owik_checker u_owik_checker (.*);
